// File: rtl/core/osp_pkg.sv
// Package: shared types, constants and the quarter-wave sine table of the open-loop sine PWM.
package osp_pkg;

   // Sizing
   localparam int SINE_TABLE_BITS = 8;
   localparam int COMPARE_BITS    = 16;

   localparam int ANGLE_W     = 32;
   localparam int PEND_W      = 24;
   localparam int PHASE_W     = 8;
   localparam int CMP_W       = 17;
   localparam int VEL_W       = 32;
   localparam int AMP_W       = 16;
   localparam int PER_W       = 17;
   localparam int DIV_W       = 8;
   localparam int ELAPSED_W   = 16;
   localparam int ANGLE_OUT_W = 16;
   localparam int DATA_W      = 32;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_IDX_W   = 3;

   // Sine table geometry
   localparam int QTR_STEPS      = 1 << (SINE_TABLE_BITS - 2);
   localparam int SINE_ROM_DEPTH = QTR_STEPS + 1;
   localparam int SINE_IDX_W     = SINE_TABLE_BITS - 1;
   localparam int Z_SHIFT        = 16 - (SINE_TABLE_BITS - 2);
   localparam int SINE_MAG_W     = 17;
   localparam int SINE_V_W       = SINE_MAG_W + 1;

   // Shared multiplier and duty arithmetic
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 25;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int DUTY_W  = 36;
   localparam int DQ_W    = COMPARE_BITS + 1;

   localparam int NUM_PH = 3;
   localparam logic [1:0] LAST_CH = 2'(NUM_PH - 1);

   localparam logic [ANGLE_W-1:0]       THIRD_TURN = 32'h5555_5555;
   localparam logic [PEND_W-1:0]        PEND_MAX   = '1;
   localparam logic signed [DUTY_W-1:0] DUTY_HALF  = 36'sh0_8000_0000;
   localparam logic [DUTY_W-2:0]        DUTY_FULL  = 35'h1_0000_0000;

   // Reset values of the configuration registers
   localparam logic [VEL_W-1:0] VEL_RESET = '0;
   localparam logic [AMP_W-1:0] AMP_RESET = 16'd16384;
   localparam logic [PER_W-1:0] PER_RESET = 17'd4096;
   localparam logic [DIV_W-1:0] DIV_RESET = 8'd2;
   localparam logic [CMP_W-1:0] CMP_RESET = CMP_W'(PER_RESET >> 1);

   // Quarter-wave polynomial coefficients
   localparam longint unsigned POLY_A = 102944;
   localparam longint unsigned POLY_B = 42334;
   localparam longint unsigned POLY_C = 5223;
   localparam longint unsigned POLY_D = 307;
   localparam longint unsigned SINE_CLAMP = 65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANGLE_VELOCITY  = 3'd0,
      CSR_AMPLITUDE_RATIO = 3'd1,
      CSR_PWM_PERIOD      = 3'd2,
      CSR_EVENT_DIVIDER   = 3'd3,
      CSR_OUTPUT_ENABLE   = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [VEL_W-1:0] angle_velocity;
      logic [AMP_W-1:0] amplitude_ratio;
      logic [PER_W-1:0] pwm_period;
      logic [DIV_W-1:0] event_divider;
      logic             output_enable;
   } cfg_type;

   typedef struct packed {
      logic [ELAPSED_W-1:0] interval_us;
      logic                 restart;
   } req_type;

   typedef struct packed {
      logic [CMP_W-1:0]       compare_ch1;
      logic [CMP_W-1:0]       compare_ch2;
      logic [CMP_W-1:0]       compare_ch3;
      logic                   updated;
      logic [ANGLE_OUT_W-1:0] angle_out;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_COUNT,
      OP_MUL_ANGLE,
      OP_ADD_ANGLE,
      OP_SINE,
      OP_MUL_AMP,
      OP_SAT,
      OP_MUL_PER,
      OP_STORE,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] ch;
      logic       updated;
   } ctrl_cmd_type;

   typedef struct packed {
      logic fire;
      logic enable;
   } dp_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COUNT,
      ST_MUL_ANGLE,
      ST_ADD_ANGLE,
      ST_SINE,
      ST_MUL_AMP,
      ST_SAT,
      ST_MUL_PER,
      ST_STORE,
      ST_WRITE
   } st_type;

   typedef logic [SINE_ROM_DEPTH-1:0][SINE_MAG_W-1:0] sine_rom_type;

   // Evaluate the quarter-wave polynomial once per table step
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type    rom;
      longint unsigned z;
      longint unsigned z2;
      longint unsigned t;
      for (int k = 0; k < SINE_ROM_DEPTH; k++) begin
         z  = longint'(k) << Z_SHIFT;
         z2 = (z * z) >> 16;
         t  = POLY_C - ((POLY_D * z2) >> 16);
         t  = POLY_B - ((t * z2) >> 16);
         t  = POLY_A - ((t * z2) >> 16);
         t  = (t * z) >> 16;
         if (t > SINE_CLAMP) begin
            t = SINE_CLAMP;
         end
         rom[k] = SINE_MAG_W'(t);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

// File: rtl/core/open_loop_sine_pwm_generator_top.sv
// Top level: open-loop three-phase sine PWM compare generator.
// Flow: an accepted event passes the count state, then the write state loads the output
// register; when the angle advances, the angle step and, per phase, the sine, amplitude,
// saturation, period and store states come between (one shared multiplier runs seven
// products: the angle step, then amplitude and period for each phase). A new event is taken
// only once the last is loaded; a result not yet taken holds the next one in its output stage.
// Reset (synchronous): angle, divider phase and gathered time clear, compares go neutral.
module open_loop_sine_pwm_generator_top import osp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0]     pwdata,
   output logic [DATA_W-1:0]     prdata,
   output logic                  pready
);

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   osp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   osp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   osp_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cfg      (cfg),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

// File: rtl/core/osp_csr.sv
// Configuration register file behind the APB-style port.
module osp_csr import osp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0]     pwdata,
   output logic [DATA_W-1:0]     prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic        wr_en;
   csr_idx_type idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = csr_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign cfg    = cfg_ff;

   // Decode a write transfer
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            CSR_ANGLE_VELOCITY:  cfg_in.angle_velocity  = pwdata[VEL_W-1:0];
            CSR_AMPLITUDE_RATIO: cfg_in.amplitude_ratio = pwdata[AMP_W-1:0];
            CSR_PWM_PERIOD:      cfg_in.pwm_period      = pwdata[PER_W-1:0];
            CSR_EVENT_DIVIDER:   cfg_in.event_divider   = pwdata[DIV_W-1:0];
            CSR_OUTPUT_ENABLE:   cfg_in.output_enable   = pwdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle_velocity  <= VEL_RESET;
         cfg_ff.amplitude_ratio <= AMP_RESET;
         cfg_ff.pwm_period      <= PER_RESET;
         cfg_ff.event_divider   <= DIV_RESET;
         cfg_ff.output_enable   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      prdata = '0;
      unique case (idx)
         CSR_ANGLE_VELOCITY:  prdata = cfg_ff.angle_velocity;
         CSR_AMPLITUDE_RATIO: prdata = DATA_W'(cfg_ff.amplitude_ratio);
         CSR_PWM_PERIOD:      prdata = DATA_W'(cfg_ff.pwm_period);
         CSR_EVENT_DIVIDER:   prdata = DATA_W'(cfg_ff.event_divider);
         CSR_OUTPUT_ENABLE:   prdata = DATA_W'(cfg_ff.output_enable);
         default:             prdata = '0;
      endcase
   end

endmodule

// File: rtl/core/osp_ctrl.sv
// Controller: sequences one event through the shared-multiplier datapath.
module osp_ctrl import osp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   st_type     state_ff;
   st_type     state_in;
   logic [1:0] ch_ff;
   logic [1:0] ch_in;
   logic       upd_ff;
   logic       upd_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         upd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         upd_ff       <= upd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      upd_in       = upd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = OP_NONE;
      cmd.ch       = ch_ff;
      cmd.updated  = upd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            cmd.op = OP_COUNT;
            ch_in  = '0;
            if (status.enable && status.fire) begin
               upd_in   = 1'b1;
               state_in = ST_MUL_ANGLE;
            end else begin
               upd_in   = 1'b0;
               state_in = ST_WRITE;
            end
         end
         ST_MUL_ANGLE: begin
            cmd.op   = OP_MUL_ANGLE;
            state_in = ST_ADD_ANGLE;
         end
         ST_ADD_ANGLE: begin
            cmd.op   = OP_ADD_ANGLE;
            state_in = ST_SINE;
         end
         ST_SINE: begin
            cmd.op   = OP_SINE;
            state_in = ST_MUL_AMP;
         end
         ST_MUL_AMP: begin
            cmd.op   = OP_MUL_AMP;
            state_in = ST_SAT;
         end
         ST_SAT: begin
            cmd.op   = OP_SAT;
            state_in = ST_MUL_PER;
         end
         ST_MUL_PER: begin
            cmd.op   = OP_MUL_PER;
            state_in = ST_STORE;
         end
         ST_STORE: begin
            cmd.op = OP_STORE;
            if (ch_ff == LAST_CH) begin
               state_in = ST_WRITE;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = ST_SINE;
            end
         end
         ST_WRITE: begin
            // Load the output register once the previous transfer is gone
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // An accepted event keeps the input closed through the count state and the state after it
   a_accept_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("input reopened too early");

   // The last phase leads to the output stage
   a_last_phase: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STORE && ch_ff == LAST_CH |=> state_ff == ST_WRITE)
      else $error("phase sequence did not finish");

   // Phase counter stays within the three phases
   a_ch_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STORE |-> ch_ff <= LAST_CH)
      else $error("phase index out of range");

endmodule

// File: rtl/core/osp_dp.sv
// Datapath: event counting, angle, sine lookup, shared multiplier and compare registers.
module osp_dp import osp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  cfg_type       cfg,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   output rsp_type       rsp_data
);

   // Architectural state
   logic [ANGLE_W-1:0] angle_ff;
   logic [PHASE_W-1:0] phase_ff;
   logic [PEND_W-1:0]  pending_ff;
   logic [CMP_W-1:0]   held_ff [NUM_PH];

   // Work registers
   logic [ELAPSED_W-1:0]       elapsed_ff;
   logic                       restart_ff;
   logic signed [MUL_P_W-1:0]  prod_ff;
   logic signed [SINE_V_W-1:0] v_ff;
   logic [DQ_W-1:0]            dq_ff;
   rsp_type                    rsp_ff;

   // Event counting
   logic [PEND_W-1:0]  pend_base;
   logic [PEND_W:0]    pend_sum;
   logic [PEND_W-1:0]  pend_sat;
   logic [PHASE_W-1:0] ph_base;
   logic [PHASE_W-1:0] ph_next;
   logic [DIV_W-1:0]   div_eff;
   logic               fire;
   logic [ANGLE_W-1:0] angle_base;

   // Sine lookup
   logic [ANGLE_W-1:0]          ph_angle;
   logic [SINE_TABLE_BITS-1:0]  sidx;
   logic [1:0]                  quad;
   logic [SINE_IDX_W-1:0]       rom_idx;
   logic [SINE_MAG_W-1:0]       mag;
   logic signed [SINE_V_W-1:0]  v_now;

   // Multiplier and duty
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;
   logic signed [DUTY_W-1:0]  duty;
   logic [DUTY_W-2:0]         duty_sat;
   logic [CMP_W-1:0]          neutral;

   assign neutral  = cfg.pwm_period >> 1;
   assign rsp_data = rsp_ff;

   // Restart, gather time and advance the divider phase
   always_comb begin
      pend_base  = restart_ff ? '0 : pending_ff;
      pend_sum   = {1'b0, pend_base} + (PEND_W + 1)'(elapsed_ff);
      pend_sat   = pend_sum[PEND_W] ? PEND_MAX : pend_sum[PEND_W-1:0];
      ph_base    = restart_ff ? '0 : phase_ff;
      ph_next    = ph_base + PHASE_W'(1);
      div_eff    = (cfg.event_divider == '0) ? DIV_W'(1) : cfg.event_divider;
      fire       = (ph_next >= div_eff) || (ph_next == '0);
      angle_base = restart_ff ? '0 : angle_ff;
   end

   assign status.fire   = fire;
   assign status.enable = cfg.output_enable;

   // Phase angle of the current channel and its quarter-wave lookup
   always_comb begin
      case (cmd.ch)
         2'd0:    ph_angle = angle_ff + THIRD_TURN;
         2'd1:    ph_angle = angle_ff - THIRD_TURN;
         default: ph_angle = angle_ff;
      endcase
      sidx    = ph_angle[ANGLE_W-1 -: SINE_TABLE_BITS];
      quad    = sidx[SINE_TABLE_BITS-1 -: 2];
      rom_idx = {1'b0, sidx[SINE_TABLE_BITS-3:0]};
      if (quad[0]) begin
         rom_idx = SINE_IDX_W'(QTR_STEPS) - rom_idx;
      end
      mag = SINE_ROM[rom_idx];
      // Phase voltage is the negated sine
      v_now = quad[1] ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
   end

   // Operand selection for the shared multiplier
   always_comb begin
      case (cmd.op)
         OP_MUL_ANGLE: begin
            mul_a = $signed({1'b0, cfg.angle_velocity});
            mul_b = $signed({1'b0, pending_ff});
         end
         OP_MUL_AMP: begin
            mul_a = $signed(MUL_A_W'(cfg.amplitude_ratio));
            mul_b = MUL_B_W'(v_ff);
         end
         default: begin
            mul_a = $signed(MUL_A_W'(dq_ff));
            mul_b = $signed(MUL_B_W'(cfg.pwm_period));
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // Offset by half scale and saturate to the full duty range
   always_comb begin
      duty = DUTY_HALF + $signed(prod_ff[DUTY_W-1:0]);
      if (duty[DUTY_W-1]) begin
         duty_sat = '0;
      end else if (duty[DUTY_W-2:0] > DUTY_FULL) begin
         duty_sat = DUTY_FULL;
      end else begin
         duty_sat = duty[DUTY_W-2:0];
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff   <= '0;
         phase_ff   <= '0;
         pending_ff <= '0;
         for (int k = 0; k < NUM_PH; k++) begin
            held_ff[k] <= CMP_RESET;
         end
      end else begin
         case (cmd.op)
            OP_COUNT: begin
               angle_ff   <= angle_base;
               pending_ff <= pend_sat;
               phase_ff   <= fire ? '0 : ph_next;
               if (!cfg.output_enable) begin
                  for (int k = 0; k < NUM_PH; k++) begin
                     held_ff[k] <= neutral;
                  end
               end
            end
            OP_ADD_ANGLE: begin
               angle_ff   <= angle_ff + prod_ff[ANGLE_W-1:0];
               pending_ff <= '0;
            end
            OP_STORE: begin
               case (cmd.ch)
                  2'd0:    held_ff[0] <= prod_ff[COMPARE_BITS +: CMP_W];
                  2'd1:    held_ff[1] <= prod_ff[COMPARE_BITS +: CMP_W];
                  default: held_ff[2] <= prod_ff[COMPARE_BITS +: CMP_W];
               endcase
            end
            default: begin
               angle_ff <= angle_ff;
            end
         endcase
      end
   end

   // Work registers, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         elapsed_ff <= req_data.interval_us;
         restart_ff <= req_data.restart;
      end
      if (cmd.op == OP_MUL_ANGLE || cmd.op == OP_MUL_AMP || cmd.op == OP_MUL_PER) begin
         prod_ff <= mul_p;
      end
      if (cmd.op == OP_SINE) begin
         v_ff <= v_now;
      end
      // Keep the duty fraction down to COMPARE_BITS of its Q32 scale
      if (cmd.op == OP_SAT) begin
         dq_ff <= duty_sat[(32 - COMPARE_BITS) +: DQ_W];
      end
      if (cmd.op == OP_OUT) begin
         rsp_ff.compare_ch1 <= held_ff[0];
         rsp_ff.compare_ch2 <= held_ff[1];
         rsp_ff.compare_ch3 <= held_ff[2];
         rsp_ff.updated     <= cmd.updated;
         rsp_ff.angle_out   <= angle_ff[ANGLE_W-1 -: ANGLE_OUT_W];
      end
   end

   // Divider phase stays below the effective divider after counting
   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_COUNT |=> phase_ff < $past(div_eff))
      else $error("divider phase not below divider");

   // A computed compare never exceeds the period
   a_cmp_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_MUL_PER |=>
         prod_ff[COMPARE_BITS +: CMP_W] <= $past(cfg.pwm_period))
      else $error("compare above period");

   // Time gathered is dropped once the angle advances
   a_pend_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_ADD_ANGLE |=> pending_ff == '0 && angle_ff == $past(angle_ff + prod_ff[ANGLE_W-1:0]))
      else $error("angle advance lost");

endmodule

// File: sim/osp_checker.sv
`timescale 1ns / 100ps
// Checker: watches the event, result and register ports, predicts compares and counts mismatches.
module osp_checker import osp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0]     pwdata,
   output int                    owed_results,
   output int                    mismatch_count
);

   localparam logic [PEND_W-1:0]  GATHER_MAX  = 24'hFF_FFFF;
   localparam logic [ANGLE_W-1:0] ANGLE_THIRD = 32'h5555_5555;
   localparam longint SIN_A     = 102944;
   localparam longint SIN_B     = 42334;
   localparam longint SIN_C     = 5223;
   localparam longint SIN_D     = 307;
   localparam longint SIN_LIMIT = 65536;
   localparam longint DUTY_MID  = 64'sd2147483648;
   localparam longint DUTY_TOP  = 64'sd4294967296;

   cfg_type            cfg_shadow;
   logic [ANGLE_W-1:0] elec_angle;
   logic [PHASE_W-1:0] div_count;
   logic [PEND_W-1:0]  gathered_us;
   logic [CMP_W-1:0]   held_cmp [NUM_PH];
   rsp_type            compare_queue [$];
   int                 results_checked;

   // Signed Q16 sine from the quarter-wave polynomial at table resolution
   function automatic longint sine_q16(input logic [ANGLE_W-1:0] ang);
      logic [SINE_TABLE_BITS-1:0] idx;
      logic [1:0]                 quad;
      longint                     z;
      longint                     z2;
      longint                     t;
      idx  = ang[ANGLE_W-1 -: SINE_TABLE_BITS];
      quad = idx[SINE_TABLE_BITS-1 -: 2];
      z    = longint'(idx[SINE_TABLE_BITS-3:0]) << (16 - (SINE_TABLE_BITS - 2));
      if (quad[0]) begin
         z = SIN_LIMIT - z;
      end
      z2 = (z * z) >> 16;
      t  = SIN_C - ((SIN_D * z2) >> 16);
      t  = SIN_B - ((t * z2) >> 16);
      t  = SIN_A - ((t * z2) >> 16);
      t  = (t * z) >> 16;
      if (t > SIN_LIMIT) begin
         t = SIN_LIMIT;
      end
      return quad[1] ? -t : t;
   endfunction

   // Duty from the inverted sine, saturated, quantized, then scaled by the period
   function automatic logic [CMP_W-1:0] phase_compare(input logic [ANGLE_W-1:0] ang);
      longint duty;
      longint scaled;
      duty = DUTY_MID + longint'({1'b0, cfg_shadow.amplitude_ratio}) * (-sine_q16(ang));
      if (duty < 0) begin
         duty = 0;
      end
      if (duty > DUTY_TOP) begin
         duty = DUTY_TOP;
      end
      duty   = duty >> (32 - COMPARE_BITS);
      scaled = (duty * longint'({1'b0, cfg_shadow.pwm_period})) >> COMPARE_BITS;
      return scaled[CMP_W-1:0];
   endfunction

   // Advance the shadow state by one compare event and form its result
   task automatic predict_event(input req_type ev, output rsp_type res);
      int               sum;
      logic [DIV_W-1:0] div_eff;
      logic             fire;
      if (ev.restart) begin
         elec_angle  = '0;
         div_count   = '0;
         gathered_us = '0;
      end
      sum         = int'(gathered_us) + int'(ev.interval_us);
      gathered_us = (sum > int'(GATHER_MAX)) ? GATHER_MAX : sum[PEND_W-1:0];
      div_eff     = (cfg_shadow.event_divider == '0) ? DIV_W'(1) : cfg_shadow.event_divider;
      div_count   = div_count + 1'b1;
      fire        = (div_count >= div_eff) || (div_count == '0);
      if (fire) begin
         div_count = '0;
      end
      res.updated = 1'b0;
      if (!cfg_shadow.output_enable) begin
         foreach (held_cmp[k]) held_cmp[k] = cfg_shadow.pwm_period >> 1;
      end else if (fire) begin
         elec_angle  = elec_angle + cfg_shadow.angle_velocity * gathered_us;
         gathered_us = '0;
         held_cmp[0] = phase_compare(elec_angle + ANGLE_THIRD);
         held_cmp[1] = phase_compare(elec_angle - ANGLE_THIRD);
         held_cmp[2] = phase_compare(elec_angle);
         res.updated = 1'b1;
      end
      res.compare_ch1 = held_cmp[0];
      res.compare_ch2 = held_cmp[1];
      res.compare_ch3 = held_cmp[2];
      res.angle_out   = elec_angle[ANGLE_W-1 -: ANGLE_OUT_W];
   endtask

   task automatic check_field(input string fname, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("Mismatch in %s of result %0d: expected %0d, got %0d",
                     fname, results_checked, want, got);
         end
      end
   endtask

   // Track register writes, compare result transfers, predict event transfers
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg_shadow.angle_velocity  = VEL_RESET;
         cfg_shadow.amplitude_ratio = AMP_RESET;
         cfg_shadow.pwm_period      = PER_RESET;
         cfg_shadow.event_divider   = DIV_RESET;
         cfg_shadow.output_enable   = 1'b0;
         elec_angle  = '0;
         div_count   = '0;
         gathered_us = '0;
         foreach (held_cmp[k]) held_cmp[k] = PER_RESET >> 1;
         compare_queue.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (csr_idx_type'(paddr[CSR_ADDR_W-1:2]))
               CSR_ANGLE_VELOCITY:  cfg_shadow.angle_velocity  = pwdata[VEL_W-1:0];
               CSR_AMPLITUDE_RATIO: cfg_shadow.amplitude_ratio = pwdata[AMP_W-1:0];
               CSR_PWM_PERIOD:      cfg_shadow.pwm_period      = pwdata[PER_W-1:0];
               CSR_EVENT_DIVIDER:   cfg_shadow.event_divider   = pwdata[DIV_W-1:0];
               CSR_OUTPUT_ENABLE:   cfg_shadow.output_enable   = pwdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (compare_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Result %0d arrived with no event waiting", results_checked);
               end
            end else begin
               want = compare_queue.pop_front();
               check_field("compare_ch1", 32'(rsp_data.compare_ch1), 32'(want.compare_ch1));
               check_field("compare_ch2", 32'(rsp_data.compare_ch2), 32'(want.compare_ch2));
               check_field("compare_ch3", 32'(rsp_data.compare_ch3), 32'(want.compare_ch3));
               check_field("updated", 32'(rsp_data.updated), 32'(want.updated));
               check_field("angle_out", 32'(rsp_data.angle_out), 32'(want.angle_out));
            end
         end
         if (req_valid && req_ready) begin
            predict_event(req_data, want);
            compare_queue.push_back(want);
         end
      end
      owed_results = compare_queue.size();
   end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, event stimulus and register settings for the sine PWM generator.
module tb;
   import osp_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [DATA_W-1:0]     pwdata;
   logic [DATA_W-1:0]     prdata;
   logic                  pready;

   int events_sent;
   int results_taken;
   int updates_seen;
   int settings_applied;
   int gap_pct;
   int results_owed;
   int mismatch_total;
   bit hold_done;

   open_loop_sine_pwm_generator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   osp_checker chk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .owed_results   (results_owed),
      .mismatch_count (mismatch_total)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Count result transfers for the receiver schedule and the summary
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_taken++;
         if (rsp_data.updated) begin
            updates_seen++;
         end
      end
   end

   // Receiver: random stalls, one long hold-off, then a stretch with no stalls
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && results_taken >= 100) begin
            hold_done = 1'b1;
            rsp_ready = 1'b0;
            repeat (300) @(negedge clock);
         end else if (results_taken >= 200 && results_taken < 300) begin
            rsp_ready = 1'b1;
         end else begin
            rsp_ready = ($urandom_range(0, 99) >= 10);
         end
      end
   end

   // Offer one event, with an occasional gap first, and hold it until the transfer
   task automatic push_event(input logic [ELAPSED_W-1:0] us, input logic rs);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid            = 1'b1;
      req_data.interval_us = us;
      req_data.restart     = rs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      events_sent++;
      @(negedge clock);
   endtask

   // Stop offering and let every owed result come back
   task automatic drain();
      req_valid = 1'b0;
      while (results_owed != 0) @(negedge clock);
      repeat (25) @(negedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [DATA_W-1:0] val);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = val;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic apply_setting(input logic [VEL_W-1:0] vel, input logic [AMP_W-1:0] amp,
                                input logic [PER_W-1:0] per, input logic [DIV_W-1:0] div,
                                input logic en);
      drain();
      write_reg(CSR_ANGLE_VELOCITY, DATA_W'(vel));
      write_reg(CSR_AMPLITUDE_RATIO, DATA_W'(amp));
      write_reg(CSR_PWM_PERIOD, DATA_W'(per));
      write_reg(CSR_EVENT_DIVIDER, DATA_W'(div));
      write_reg(CSR_OUTPUT_ENABLE, DATA_W'(en));
      settings_applied++;
   endtask

   // Random events with elapsed time in [lo, hi], the bounds hit often
   task automatic run_events(input int count, input int lo, input int hi, input int restart_pct);
      logic [ELAPSED_W-1:0] us;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 19))
            0:       us = ELAPSED_W'(lo);
            1, 2:    us = ELAPSED_W'(hi);
            default: us = ELAPSED_W'($urandom_range(lo, hi));
         endcase
         push_event(us, (n > 0) && ($urandom_range(0, 99) < restart_pct));
      end
   endtask

   initial begin
      logic [VEL_W-1:0] vel;
      logic [AMP_W-1:0] amp;
      logic [PER_W-1:0] per;
      logic [DIV_W-1:0] div;
      reset    = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      gap_pct   = 10;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Reset settings: output disabled, compares neutral
      push_event(16'd0, 1'b0);
      push_event(16'hFFFF, 1'b1);

      // Quarter-turn steps walk all four sine quadrants
      apply_setting(32'h0010_0000, 16'd32768, 17'd65536, 8'd1, 1'b1);
      push_event(16'd0, 1'b1);
      repeat (4) push_event(16'd1024, 1'b0);
      push_event(16'd341, 1'b0);
      push_event(16'hFFFF, 1'b0);

      // Zero period gives zero compares
      apply_setting(32'h0010_0000, 16'd32768, 17'd0, 8'd1, 1'b1);
      repeat (2) push_event(16'd1000, 1'b0);

      // Amplitude above one half saturates the duty
      apply_setting(32'h0010_0000, 16'hFFFF, 17'd65536, 8'd1, 1'b1);
      repeat (3) push_event(16'd512, 1'b0);

      // Zero divider acts as one
      apply_setting(32'h0010_0000, 16'd16384, 17'd4096, 8'd0, 1'b1);
      repeat (2) push_event(16'd700, 1'b0);

      // Velocity extremes
      apply_setting(32'h8000_0000, 16'd16384, 17'd4096, 8'd1, 1'b1);
      push_event(16'd1, 1'b0);
      push_event(16'd3, 1'b0);
      apply_setting(32'h7FFF_FFFF, 16'd16384, 17'd4096, 8'd1, 1'b1);
      push_event(16'd1, 1'b0);
      push_event(16'd2, 1'b0);

      // Random phases; after the first, a long disabled stretch saturates the gathered time
      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       vel = 32'h7FFF_FFFF;
            1:       vel = 32'h8000_0000;
            default: vel = $urandom;
         endcase
         case (p % 4)
            0:       amp = 16'd32768;
            1:       amp = 16'd0;
            2:       amp = 16'hFFFF;
            default: amp = AMP_W'($urandom_range(0, 32768));
         endcase
         case (p)
            0:       per = 17'd65536;
            1:       per = 17'h1FFFF;
            2:       per = 17'd1;
            default: per = PER_W'($urandom_range(1, 65536));
         endcase
         case (p)
            0:       div = 8'd1;
            1:       div = 8'd255;
            2:       div = 8'd3;
            default: div = DIV_W'($urandom_range(0, 8));
         endcase
         apply_setting(vel, amp, per, div, p != 4);
         run_events(50, 0, 65535, (p == 1) ? 0 : 5);
         if (p == 0) begin
            apply_setting($urandom, 16'd16384, 17'd4096, 8'd2, 1'b0);
            run_events(100, 64500, 65535, 0);
            gap_pct = 0;
            run_events(100, 64500, 65535, 0);
            gap_pct = 10;
            run_events(62, 64500, 65535, 0);
         end
      end

      drain();
      $display("Sent %0d compare events over %0d register settings; %0d results checked, %0d updates.",
               events_sent, settings_applied, results_taken, updates_seen);
      $display("Covered disabled output, zero period and divider, saturated duty and gathered time.");
      if (mismatch_total == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog against a hung handshake
   initial begin
      #5_000_000;
      $display("Run stalled with %0d results still owed", results_owed);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/osp_pkg.sv
rtl/core/osp_csr.sv
rtl/core/osp_ctrl.sv
rtl/core/osp_dp.sv
rtl/core/open_loop_sine_pwm_generator_top.sv
sim/osp_checker.sv
sim/tb.sv
